// ===== sv/pmvg_pkg.sv =====
// pmvg_pkg: shared types, constants and arithmetic helpers of the mesh vertex generator
// no dependencies; compiled first
package pmvg_pkg;

  localparam logic [1:0] MODE_RECT  = 2'd0;
  localparam logic [1:0] MODE_FULL  = 2'd1;
  localparam logic [1:0] MODE_HALF  = 2'd2;
  localparam logic [1:0] MODE_TORUS = 2'd3;

  localparam logic [1:0] REG_SHAPE_MODE = 2'd0;
  localparam logic [1:0] REG_GRID_RES   = 2'd1;
  localparam logic [1:0] REG_FIRST_DIM  = 2'd2;
  localparam logic [1:0] REG_SECOND_DIM = 2'd3;

  localparam int NUMW          = 40;
  localparam int CORDIC_STEPS  = 24;
  localparam int CW            = 34;
  localparam int ZW            = 33;
  localparam logic signed [CW-1:0] CORDIC_GAIN = 34'sd652032874;

  localparam logic [31:0] ATAN_TAB [CORDIC_STEPS] = '{
    32'd536870912, 32'd316933406, 32'd167458907, 32'd85004756, 32'd42667331,
    32'd21354465, 32'd10679838, 32'd5340245, 32'd2670163, 32'd1335087,
    32'd667544, 32'd333772, 32'd166886, 32'd83443, 32'd41722, 32'd20861,
    32'd10430, 32'd5215, 32'd2608, 32'd1304, 32'd652, 32'd326, 32'd163, 32'd81
  };

  typedef struct packed {
    logic signed [CW-1:0] x;
    logic signed [CW-1:0] y;
    logic signed [ZW-1:0] z;
    logic [1:0]           q;
  } cordic_t;

  typedef struct packed {
    logic signed [CW-1:0] c;
    logic signed [CW-1:0] s;
  } sc_t;

  typedef struct packed {
    logic [1:0]         mode;
    logic               err;
    logic               neg_x;
    logic               neg_y;
    logic signed [31:0] rect_x;
    logic signed [31:0] rect_y;
    logic [31:0]        radius;
    logic [30:0]        dim_f;
    logic [30:0]        dim_s;
  } side_t;

  // Q2.30 product, rounded to nearest with halves up
  function automatic logic signed [37:0] rnd_q30(input logic signed [67:0] p);
    logic signed [67:0] t;
    t = p + 68'sd536870912;
    return t[67:30];
  endfunction

  function automatic logic signed [31:0] sat32(input logic signed [37:0] v);
    if (v > 38'sd2147483647) return 32'sh7fffffff;
    if (v < -38'sd2147483648) return 32'sh80000000;
    return v[31:0];
  endfunction

  function automatic sc_t rotate_quadrant(input cordic_t r);
    sc_t o;
    case (r.q)
      2'd0: begin
        o.c = r.x;  o.s = r.y;
      end
      2'd1: begin
        o.c = -r.y; o.s = r.x;
      end
      2'd2: begin
        o.c = -r.x; o.s = -r.y;
      end
      default: begin
        o.c = r.y;  o.s = -r.x;
      end
    endcase
    return o;
  endfunction

endpackage

// ===== sv/pmvg_if.sv =====
// pmvg_if: request channels of the mesh vertex generator (grid point in, vertex out)
// no dependencies
interface pmvg_point_if;
  logic       valid;
  logic       ready;
  logic [7:0] row_index;
  logic [7:0] column_index;
  modport source(output valid, row_index, column_index, input ready);
  modport sink(input valid, row_index, column_index, output ready);
endinterface

interface pmvg_vertex_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] x_coord;
  logic signed [31:0] y_coord;
  logic signed [31:0] z_coord;
  logic               index_error;
  modport source(output valid, x_coord, y_coord, z_coord, index_error, input ready);
  modport sink(input valid, x_coord, y_coord, z_coord, index_error, output ready);
endinterface

// ===== sv/pmvg_div_cell.sv =====
// pmvg_div_cell: one restoring division step, one quotient bit per cell
// depends on pmvg_pkg
module pmvg_div_cell #(
  parameter int DVW = 9
) (
  input  logic                          clk,
  input  logic                          en,
  input  logic [DVW-1:0]                rem_in,
  input  logic [pmvg_pkg::NUMW-1:0]     num_in,
  input  logic [pmvg_pkg::NUMW-1:0]     quo_in,
  input  logic [DVW-1:0]                dvs_in,
  output logic [DVW-1:0]                rem_out,
  output logic [pmvg_pkg::NUMW-1:0]     num_out,
  output logic [pmvg_pkg::NUMW-1:0]     quo_out,
  output logic [DVW-1:0]                dvs_out
);
  import pmvg_pkg::*;

  logic [DVW:0] trial;
  logic [DVW:0] diff;
  logic         ge;

  assign trial = {rem_in, num_in[NUMW-1]};
  assign ge    = trial >= {1'b0, dvs_in};
  assign diff  = trial - {1'b0, dvs_in};

  always_ff @(posedge clk) begin
    if (en) begin
      rem_out <= ge ? diff[DVW-1:0] : trial[DVW-1:0];
      num_out <= {num_in[NUMW-2:0], 1'b0};
      quo_out <= {quo_in[NUMW-2:0], ge};
      dvs_out <= dvs_in;
    end
  end
endmodule

// ===== sv/pmvg_cordic_cell.sv =====
// pmvg_cordic_cell: one rotation-mode cordic iteration with floor shifts
// depends on pmvg_pkg
module pmvg_cordic_cell #(
  parameter int STEP = 0
) (
  input  logic              clk,
  input  logic              en,
  input  pmvg_pkg::cordic_t cin,
  output pmvg_pkg::cordic_t cout
);
  import pmvg_pkg::*;

  logic signed [CW-1:0] dx;
  logic signed [CW-1:0] dy;
  logic signed [ZW-1:0] at;

  assign dx = cin.y >>> STEP;
  assign dy = cin.x >>> STEP;
  assign at = $signed({1'b0, ATAN_TAB[STEP]});

  always_ff @(posedge clk) begin
    if (en) begin
      cout.q <= cin.q;
      if (!cin.z[ZW-1]) begin
        cout.x <= cin.x - dx;
        cout.y <= cin.y + dy;
        cout.z <= cin.z - at;
      end else begin
        cout.x <= cin.x + dx;
        cout.y <= cin.y - dy;
        cout.z <= cin.z + at;
      end
    end
  end
endmodule

// ===== sv/parametric_mesh_vertex_generator_core.sv =====
// parametric_mesh_vertex_generator_core: top level, grid point to surface vertex
// depends on pmvg_pkg, pmvg_if, pmvg_div_cell, pmvg_cordic_cell
// throughput: one request per cycle; 40 divider and 24 cordic cell pairs, 5 other stages
// all advance together and hold only while the output register is full and not taken
// reset (rst, synchronous): pipeline emptied, registers to torus, 32 points, 1.0 and 0.5
module parametric_mesh_vertex_generator_core #(
  parameter int MAX_RESOLUTION = 256
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                wr_en,
  input  logic [1:0]          wr_index,
  input  logic [30:0]         wr_data,
  pmvg_point_if.sink          point,
  pmvg_vertex_if.source       vertex
);
  import pmvg_pkg::*;

  localparam int NMAX = (MAX_RESOLUTION < 511) ? MAX_RESOLUTION : 511;
  localparam int DVW  = $clog2(2 * NMAX);
  localparam int LAST = NUMW + CORDIC_STEPS + 4;

  logic [1:0]  shape_mode;
  logic [8:0]  grid_resolution;
  logic [30:0] first_dimension;
  logic [30:0] second_dimension;

  always_ff @(posedge clk) begin
    if (rst) begin
      shape_mode       <= MODE_TORUS;
      grid_resolution  <= 9'd32;
      first_dimension  <= 31'd65536;
      second_dimension <= 31'd32768;
    end else if (wr_en) begin
      case (wr_index)
        REG_SHAPE_MODE: shape_mode       <= wr_data[1:0];
        REG_GRID_RES:   grid_resolution  <= wr_data[8:0];
        REG_FIRST_DIM:  first_dimension  <= wr_data;
        REG_SECOND_DIM: second_dimension <= wr_data;
        default: ;
      endcase
    end
  end

  logic [LAST:0] vld;
  logic          en;

  assign en           = !vld[LAST] || vertex.ready;
  assign point.ready  = en;
  assign vertex.valid = vld[LAST];

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (en) begin
      vld <= {vld[LAST-1:0], point.valid};
    end
  end

  // stage 0: numerators and divisors
  logic [9:0]         n10;
  logic [9:0]         d10;
  logic [10:0]        d2w;
  logic               err;
  logic signed [10:0] si;
  logic signed [10:0] sj;
  logic [9:0]         mag_i;
  logic [9:0]         mag_j;
  logic [40:0]        rect_a;
  logic [40:0]        rect_b;
  logic [NUMW-1:0]    half_d;
  logic [NUMW-1:0]    num_a;
  logic [NUMW-1:0]    num_b;
  logic [DVW-1:0]     dvs;

  assign n10 = ({1'b0, grid_resolution} > 10'(NMAX)) ? 10'(NMAX) : {1'b0, grid_resolution};
  assign d10 = n10 - 10'd1;
  assign d2w = {d10, 1'b0};
  assign err = (n10 < 10'd2) || ({2'b0, point.row_index} >= n10)
            || ({2'b0, point.column_index} >= n10);
  assign si  = $signed({2'b0, point.row_index, 1'b0}) - $signed({1'b0, d10});
  assign sj  = $signed({2'b0, point.column_index, 1'b0}) - $signed({1'b0, d10});
  assign mag_i = si[10] ? 10'(-si) : si[9:0];
  assign mag_j = sj[10] ? 10'(-sj) : sj[9:0];
  assign rect_a = 41'(mag_i) * 41'(first_dimension) + 41'(d10);
  assign rect_b = 41'(mag_j) * 41'(second_dimension) + 41'(d10);
  assign half_d = 40'(d10[9:1]);
  assign dvs = (shape_mode == MODE_RECT) ? d2w[DVW-1:0] : d10[DVW-1:0];

  always_comb begin
    case (shape_mode)
      MODE_RECT: begin
        num_a = rect_a[NUMW-1:0];
        num_b = rect_b[NUMW-1:0];
      end
      MODE_FULL: begin
        num_a = 40'(first_dimension) * 40'(point.row_index) + half_d;
        num_b = {point.column_index, 32'b0} + half_d;
      end
      MODE_HALF: begin
        num_a = 40'(first_dimension) * 40'(point.row_index) + half_d;
        num_b = {1'b0, point.column_index, 31'b0} + half_d;
      end
      default: begin
        num_a = {point.row_index, 32'b0} + half_d;
        num_b = {point.column_index, 32'b0} + half_d;
      end
    endcase
  end

  logic [DVW-1:0]  rem_a [0:NUMW];
  logic [NUMW-1:0] nm_a  [0:NUMW];
  logic [NUMW-1:0] quo_a [0:NUMW];
  logic [DVW-1:0]  dv_a  [0:NUMW];
  logic [DVW-1:0]  rem_b [0:NUMW];
  logic [NUMW-1:0] nm_b  [0:NUMW];
  logic [NUMW-1:0] quo_b [0:NUMW];
  logic [DVW-1:0]  dv_b  [0:NUMW];
  side_t           side_d [0:NUMW];

  always_ff @(posedge clk) begin
    if (en) begin
      rem_a[0] <= '0;
      nm_a[0]  <= num_a;
      quo_a[0] <= '0;
      dv_a[0]  <= dvs;
      rem_b[0] <= '0;
      nm_b[0]  <= num_b;
      quo_b[0] <= '0;
      dv_b[0]  <= dvs;
      side_d[0].mode   <= shape_mode;
      side_d[0].err    <= err;
      side_d[0].neg_x  <= si[10];
      side_d[0].neg_y  <= sj[10];
      side_d[0].rect_x <= '0;
      side_d[0].rect_y <= '0;
      side_d[0].radius <= '0;
      side_d[0].dim_f  <= first_dimension;
      side_d[0].dim_s  <= second_dimension;
    end
  end

  for (genvar k = 0; k < NUMW; k++) begin : g_div
    pmvg_div_cell #(.DVW(DVW)) u_div_a (
      .clk(clk), .en(en),
      .rem_in(rem_a[k]), .num_in(nm_a[k]), .quo_in(quo_a[k]), .dvs_in(dv_a[k]),
      .rem_out(rem_a[k+1]), .num_out(nm_a[k+1]), .quo_out(quo_a[k+1]),
      .dvs_out(dv_a[k+1])
    );
    pmvg_div_cell #(.DVW(DVW)) u_div_b (
      .clk(clk), .en(en),
      .rem_in(rem_b[k]), .num_in(nm_b[k]), .quo_in(quo_b[k]), .dvs_in(dv_b[k]),
      .rem_out(rem_b[k+1]), .num_out(nm_b[k+1]), .quo_out(quo_b[k+1]),
      .dvs_out(dv_b[k+1])
    );
    always_ff @(posedge clk) begin
      if (en) side_d[k+1] <= side_d[k];
    end
  end

  // quotients become rectangle coordinates, sector radius and phases
  logic [31:0] qa;
  logic [31:0] qb;
  side_t       side_nq;
  cordic_t     cu [0:CORDIC_STEPS];
  cordic_t     cv [0:CORDIC_STEPS];
  side_t       side_c [0:CORDIC_STEPS];

  assign qa = quo_a[NUMW][31:0];
  assign qb = quo_b[NUMW][31:0];

  always_comb begin
    side_nq        = side_d[NUMW];
    side_nq.rect_x = side_d[NUMW].neg_x ? -$signed(qa) : $signed(qa);
    side_nq.rect_y = side_d[NUMW].neg_y ? -$signed(qb) : $signed(qb);
    side_nq.radius = qa;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      side_c[0] <= side_nq;
      cu[0].x <= CORDIC_GAIN;
      cu[0].y <= '0;
      cu[0].z <= $signed({3'b0, qa[29:0]});
      cu[0].q <= qa[31:30];
      cv[0].x <= CORDIC_GAIN;
      cv[0].y <= '0;
      cv[0].z <= $signed({3'b0, qb[29:0]});
      cv[0].q <= qb[31:30];
    end
  end

  for (genvar k = 0; k < CORDIC_STEPS; k++) begin : g_cordic
    pmvg_cordic_cell #(.STEP(k)) u_cell_u (.clk(clk), .en(en), .cin(cu[k]), .cout(cu[k+1]));
    pmvg_cordic_cell #(.STEP(k)) u_cell_v (.clk(clk), .en(en), .cin(cv[k]), .cout(cv[k+1]));
    always_ff @(posedge clk) begin
      if (en) side_c[k+1] <= side_c[k];
    end
  end

  // quadrant fold, then the two multiply stages
  sc_t   sc_u;
  sc_t   sc_v;
  side_t side_q;

  always_ff @(posedge clk) begin
    if (en) begin
      sc_u   <= rotate_quadrant(cu[CORDIC_STEPS]);
      sc_v   <= rotate_quadrant(cv[CORDIC_STEPS]);
      side_q <= side_c[CORDIC_STEPS];
    end
  end

  logic signed [CW-1:0] mul_a;
  logic signed [37:0]   pa;
  logic signed [37:0]   pb;
  sc_t                  sc_um;
  side_t                side_m;

  // torus scales the minor circle, sectors scale by radius
  assign mul_a = (side_q.mode == MODE_TORUS) ? $signed({3'b0, side_q.dim_s})
                                             : $signed({2'b0, side_q.radius});

  always_ff @(posedge clk) begin
    if (en) begin
      pa     <= rnd_q30(68'(mul_a) * 68'(sc_v.c));
      pb     <= rnd_q30(68'(mul_a) * 68'(sc_v.s));
      sc_um  <= sc_u;
      side_m <= side_q;
    end
  end

  logic signed [38:0]   t_w;
  logic signed [CW-1:0] t_ring;
  logic signed [31:0]   x_next;
  logic signed [31:0]   y_next;
  logic signed [31:0]   z_next;

  assign t_w    = $signed({8'b0, side_m.dim_f}) + 39'(pa);
  assign t_ring = t_w[CW-1:0];

  always_comb begin
    x_next = '0;
    y_next = '0;
    z_next = '0;
    if (!side_m.err) begin
      case (side_m.mode)
        MODE_RECT: begin
          x_next = side_m.rect_x;
          y_next = side_m.rect_y;
        end
        MODE_FULL, MODE_HALF: begin
          x_next = sat32(pa);
          y_next = sat32(pb);
        end
        default: begin
          x_next = sat32(rnd_q30(68'(t_ring) * 68'(sc_um.c)));
          y_next = sat32(rnd_q30(68'(t_ring) * 68'(sc_um.s)));
          z_next = sat32(pb);
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      vertex.x_coord     <= x_next;
      vertex.y_coord     <= y_next;
      vertex.z_coord     <= z_next;
      vertex.index_error <= side_m.err;
    end
  end

  a_err_zero: assert property (@(posedge clk) disable iff (rst)
    vertex.valid && vertex.index_error |->
      vertex.x_coord == 0 && vertex.y_coord == 0 && vertex.z_coord == 0)
    else $error("rejected point with nonzero coordinates");

  a_flat_z: assert property (@(posedge clk) disable iff (rst)
    vertex.valid && shape_mode != MODE_TORUS |-> vertex.z_coord == 0)
    else $error("flat shape with nonzero z");

  a_stall_hold: assert property (@(posedge clk) disable iff (rst)
    !en |=> $stable(vld))
    else $error("pipeline moved during stall");

endmodule
